@@ src/idtm_pkg.sv @@
// Package for the invalidation-driven thread migrator.
// Holds the item structs, mode and register codes, reset values and pair tables.
// No dependencies.
`default_nettype none

package idtm_pkg;

  // Input item: one access event.
  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] hw_thread;
    logic [1:0] writer_core;
    logic [1:0] victim_core;
    logic [3:0] invalidated_lines;
  } idtm_in_t;

  // Result item: one per input item.
  typedef struct packed {
    logic [1:0] virtual_id;
    logic       migrated;
    logic [1:0] flush_first;
    logic [1:0] flush_second;
  } idtm_out_t;

  // Input item modes.
  localparam logic [1:0] MODE_FETCH  = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_INVAL  = 2'd2;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_INTERVAL = 2'd1;
  localparam logic [1:0] REG_THRESH   = 2'd2;
  localparam logic [1:0] REG_KEEP     = 2'd3;

  localparam logic [31:0] INTERVAL_RST = 32'd10000;
  localparam logic [8:0]  THRESH_RST   = 9'd85;
  localparam logic [8:0]  KEEP_RST     = 9'd0;

  // The Q1.8 multipliers are nine bits, handled one bit a step, MSB first.
  localparam logic [3:0] MUL_LAST = 4'd8;

  // Cross-L2 candidate k, in the order 0-2, 0-3, 1-2, 1-3.
  // Counter index of the (a, b) direction: a*4 + b.
  function automatic logic [3:0] cand_fwd_idx(input logic [1:0] k);
    cand_fwd_idx = {1'b0, k[1], 1'b1, k[0]};
  endfunction

  // Counter index of the (b, a) direction: b*4 + a.
  function automatic logic [3:0] cand_rev_idx(input logic [1:0] k);
    cand_rev_idx = {1'b1, k[0], 1'b0, k[1]};
  endfunction

  // Map entries swapped and caches flushed when candidate k wins.
  function automatic logic [1:0] swap_lo(input logic [1:0] k);
    swap_lo = {1'b0, k[1]};
  endfunction

  function automatic logic [1:0] swap_hi(input logic [1:0] k);
    swap_hi = {1'b1, ~k[0]};
  endfunction

endpackage

`default_nettype wire

@@ src/invalidation_driven_thread_migrator.sv @@
// Top level of the invalidation-driven thread migrator: sequencer, shared adder,
// pair counters, core map and APB configuration registers.
// Depends on idtm_pkg.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   in_item_i  (idtm_in_t)
// out       output     out_valid_o / out_stall_i out_item_o (idtm_out_t)
// config    input      APB psel/penable/pwrite   paddr, pwdata -> prdata
//
// Lookups, ignored reports and unused modes go from acceptance straight to the
// done state, which loads the output register once it is free. An invalidation
// report passes through S_INV first, and a fetch that does not start a check
// through S_FETCH. Unless the interval is zero, the first fetch after the
// interval register is written first runs the bit-serial division that
// rebuilds the fetch remainder. A check walks the sixteen counters, four
// candidates and a nine-step multiply through the one shared adder; a
// migration then scales every counter by a nine-step multiply and a write.
// Reset is asynchronous and active low and needs no clearing pass. The block
// takes no item while one is in work; a stalled result waits in the output
// register while the next item is accepted.

module invalidation_driven_thread_migrator #(
  parameter int COUNTER_BITS = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire idtm_pkg::idtm_in_t in_item_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output idtm_pkg::idtm_out_t  out_item_o,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [3:0]           paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import idtm_pkg::*;

  // The adder must hold total * threshold (COUNTER_BITS + 13 bits) and the
  // 33-bit partial remainder of the fetch-count division.
  localparam int AW = (COUNTER_BITS + 13 > 34) ? COUNTER_BITS + 13 : 34;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INV   = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_FETCH = 4'd3;
  localparam logic [3:0] S_TOT   = 4'd4;
  localparam logic [3:0] S_CAND  = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_CMP   = 4'd7;
  localparam logic [3:0] S_SCL   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]  state_q, state_d;

  // Configuration registers.
  logic        enable_q;
  logic [31:0] interval_q;
  logic [8:0]  thresh_q;
  logic [8:0]  keep_q;
  logic        cfg_we;

  // Fetch bookkeeping: rem_q tracks fetch_q modulo the interval. A write of
  // the interval marks it stale, and the next fetch rebuilds it by division.
  logic [31:0] fetch_q, fetch_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] div_q, div_d;
  logic        stale_q, stale_d;

  // Captured item fields needed after acceptance.
  logic [3:0]  inv_idx_q, inv_idx_d;
  logic [3:0]  lines_q, lines_d;

  // Working registers of the check.
  logic [AW-1:0] tot_q, tot_d;
  logic [AW-1:0] best_q, best_d;
  logic [AW-1:0] prod_q, prod_d;
  logic [1:0]    bestk_q, bestk_d;
  logic [3:0]    idx_q, idx_d;
  logic [4:0]    step_q, step_d;

  logic [1:0]  cmap_q [4];
  logic [1:0]  cmap_d [4];

  idtm_out_t   res_q, res_d;
  idtm_out_t   out_q;
  logic        out_valid_q;
  logic        out_load;

  // Pair counters, index writer*4 + victim, one read port.
  logic [COUNTER_BITS-1:0] cnt_q [16];
  logic [3:0]              rd_idx;
  logic [AW-1:0]           rd_ext;
  logic                    cnt_we;
  logic [3:0]              cnt_wa;
  logic [COUNTER_BITS-1:0] cnt_wd;

  // The shared adder/subtractor.
  logic [AW-1:0] alu_a, alu_b;
  logic          alu_sub;
  logic [AW:0]   alu_sum;
  logic          alu_carry;

  logic [3:0]    bit_idx;
  logic [32:0]   div_shift;
  logic [31:0]   rem_next;
  logic [AW-1:0] scaled;
  logic          in_accept;

  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_ENABLE:   prdata = {31'd0, enable_q};
      REG_INTERVAL: prdata = interval_q;
      REG_THRESH:   prdata = {23'd0, thresh_q};
      REG_KEEP:     prdata = {23'd0, keep_q};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      interval_q <= INTERVAL_RST;
      thresh_q   <= THRESH_RST;
      keep_q     <= KEEP_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_ENABLE:   enable_q   <= pwdata[0];
        REG_INTERVAL: interval_q <= pwdata;
        REG_THRESH:   thresh_q   <= pwdata[8:0];
        REG_KEEP:     keep_q     <= pwdata[8:0];
        default:      enable_q   <= enable_q;
      endcase
    end
  end

  // Bit of the current Q1.8 multiplier, most significant first.
  assign bit_idx = MUL_LAST - step_q[3:0];
  assign div_shift = {rem_q, div_q[31]};
  assign scaled = prod_q >> 8;

  // Counter read address.
  always_comb begin
    unique case (state_q)
      S_INV:   rd_idx = inv_idx_q;
      S_CAND:  rd_idx = (step_q == 5'd0) ? cand_fwd_idx(idx_q[1:0])
                                         : cand_rev_idx(idx_q[1:0]);
      default: rd_idx = idx_q;
    endcase
  end
  assign rd_ext = AW'(cnt_q[rd_idx]);

  // Operand selection for the shared adder.
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_INV: begin
        alu_a = rd_ext;
        alu_b = AW'(lines_q);
      end
      S_DIV: begin
        alu_a = AW'(div_shift);
        alu_b = AW'(interval_q);
        alu_sub = 1'b1;
      end
      S_FETCH: begin
        alu_a = AW'(rem_q);
        alu_b = AW'(1'b1);
      end
      S_TOT: begin
        alu_a = tot_q;
        alu_b = rd_ext;
      end
      S_CAND: begin
        if (step_q == 5'd1) begin
          alu_a = prod_q;
          alu_b = rd_ext;
        end else begin
          alu_a = best_q;
          alu_b = prod_q;
          alu_sub = 1'b1;
        end
      end
      S_MUL: begin
        alu_a = prod_q << 1;
        alu_b = thresh_q[bit_idx] ? tot_q : '0;
      end
      S_CMP: begin
        alu_a = best_q << 8;
        alu_b = prod_q;
        alu_sub = 1'b1;
      end
      S_SCL: begin
        alu_a = (step_q == 5'd0) ? '0 : (prod_q << 1);
        alu_b = keep_q[bit_idx] ? rd_ext : '0;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AW + 1)'(alu_sub);
  // For a subtraction, a carry out means no borrow (a >= b).
  assign alu_carry = alu_sum[AW];

  assign rem_next = (alu_sum[31:0] == interval_q) ? '0 : alu_sum[31:0];

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    fetch_d   = fetch_q;
    rem_d     = rem_q;
    div_d     = div_q;
    stale_d   = stale_q;
    inv_idx_d = inv_idx_q;
    lines_d   = lines_q;
    tot_d     = tot_q;
    best_d    = best_q;
    prod_d    = prod_q;
    bestk_d   = bestk_q;
    idx_d     = idx_q;
    step_d    = step_q;
    cmap_d    = cmap_q;
    res_d     = res_q;
    cnt_we    = 1'b0;
    cnt_wa    = idx_q;
    cnt_wd    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          inv_idx_d = {in_item_i.writer_core, in_item_i.victim_core};
          lines_d   = in_item_i.invalidated_lines;
          res_d     = '0;
          if (in_item_i.mode == MODE_FETCH || in_item_i.mode == MODE_LOOKUP) begin
            res_d.virtual_id = enable_q ? cmap_q[in_item_i.hw_thread]
                                        : in_item_i.hw_thread;
          end
          state_d = S_DONE;
          if (in_item_i.mode == MODE_FETCH) begin
            if (!stale_q) begin
              state_d = S_FETCH;
            end else if (interval_q == '0) begin
              // An interval of zero acts as 2^32: the remainder is the count.
              rem_d   = fetch_q;
              stale_d = 1'b0;
              state_d = S_FETCH;
            end else begin
              rem_d   = '0;
              div_d   = fetch_q;
              step_d  = '0;
              state_d = S_DIV;
            end
          end else if (in_item_i.mode == MODE_INVAL &&
                       in_item_i.writer_core != in_item_i.victim_core) begin
            state_d = S_INV;
          end
        end
      end

      S_INV: begin
        // Saturating add of the invalidated line count.
        cnt_we  = 1'b1;
        cnt_wa  = inv_idx_q;
        cnt_wd  = (|alu_sum[AW-1:COUNTER_BITS]) ? '1 : alu_sum[COUNTER_BITS-1:0];
        state_d = S_DONE;
      end

      S_DIV: begin
        // Restoring division, one quotient bit per cycle; only the
        // remainder is kept.
        rem_d  = alu_carry ? alu_sum[31:0] : div_shift[31:0];
        div_d  = div_q << 1;
        step_d = step_q + 5'd1;
        if (step_q == 5'd31) begin
          stale_d = 1'b0;
          state_d = S_FETCH;
        end
      end

      S_FETCH: begin
        fetch_d = fetch_q + 32'd1;
        rem_d   = rem_next;
        if (enable_q && rem_next == '0) begin
          tot_d   = '0;
          idx_d   = '0;
          state_d = S_TOT;
        end else begin
          state_d = S_DONE;
        end
      end

      S_TOT: begin
        // Diagonal counters are never written and stay zero, so the sum of
        // all sixteen is the sum of the six symmetric pairs.
        tot_d = alu_sum[AW-1:0];
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd15) begin
          if (alu_sum[AW-1:0] == '0) begin
            state_d = S_DONE;
          end else begin
            idx_d   = '0;
            step_d  = '0;
            best_d  = '0;
            bestk_d = '0;
            state_d = S_CAND;
          end
        end
      end

      S_CAND: begin
        if (step_q == 5'd0) begin
          prod_d = rd_ext;
          step_d = 5'd1;
        end else if (step_q == 5'd1) begin
          prod_d = alu_sum[AW-1:0];
          step_d = 5'd2;
        end else begin
          // A borrow means the candidate is strictly larger; ties keep the
          // earlier pair.
          if (!alu_carry) begin
            best_d  = prod_q;
            bestk_d = idx_q[1:0];
          end
          step_d = '0;
          idx_d  = idx_q + 4'd1;
          if (idx_q[1:0] == 2'd3) begin
            prod_d  = '0;
            state_d = S_MUL;
          end
        end
      end

      S_MUL: begin
        prod_d = alu_sum[AW-1:0];
        step_d = step_q + 5'd1;
        if (step_q == 5'(MUL_LAST)) begin
          state_d = S_CMP;
        end
      end

      S_CMP: begin
        // Migrate when best * 256 >= threshold * total.
        if (alu_carry) begin
          cmap_d[swap_lo(bestk_q)] = cmap_q[swap_hi(bestk_q)];
          cmap_d[swap_hi(bestk_q)] = cmap_q[swap_lo(bestk_q)];
          res_d.migrated     = 1'b1;
          res_d.flush_first  = swap_lo(bestk_q);
          res_d.flush_second = swap_hi(bestk_q);
          idx_d   = '0;
          step_d  = '0;
          state_d = S_SCL;
        end else begin
          state_d = S_DONE;
        end
      end

      S_SCL: begin
        if (step_q == 5'(MUL_LAST) + 5'd1) begin
          cnt_we = 1'b1;
          cnt_wa = idx_q;
          cnt_wd = (|scaled[AW-1:COUNTER_BITS]) ? '1 : scaled[COUNTER_BITS-1:0];
          step_d = '0;
          idx_d  = idx_q + 4'd1;
          if (idx_q == 4'd15) begin
            state_d = S_DONE;
          end
        end else begin
          prod_d = alu_sum[AW-1:0];
          step_d = step_q + 5'd1;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we && paddr[3:2] == REG_INTERVAL) begin
      stale_d = 1'b1;
    end
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fetch_q     <= '0;
      rem_q       <= '0;
      stale_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        cmap_q[i] <= 2'(i);
      end
    end else begin
      state_q <= state_d;
      fetch_q <= fetch_d;
      rem_q   <= rem_d;
      stale_q <= stale_d;
      cmap_q  <= cmap_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    div_q     <= div_d;
    inv_idx_q <= inv_idx_d;
    lines_q   <= lines_d;
    tot_q     <= tot_d;
    best_q    <= best_d;
    prod_q    <= prod_d;
    bestk_q   <= bestk_d;
    idx_q     <= idx_d;
    step_q    <= step_d;
    res_q     <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (cnt_we) begin
      cnt_q[cnt_wa] <= cnt_wd;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // The core map stays a permutation of the four cores.
  a_map_perm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmap_q[0] != cmap_q[1] && cmap_q[0] != cmap_q[2] && cmap_q[0] != cmap_q[3] &&
    cmap_q[1] != cmap_q[2] && cmap_q[1] != cmap_q[3] && cmap_q[2] != cmap_q[3])
    else $error("core map is not a permutation");

  // A migration flushes one core of each L2 group.
  a_flush_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.migrated |->
      !out_item_o.flush_first[1] && out_item_o.flush_second[1])
    else $error("migration flush pair does not cross the L2 groups");

  // Without a migration no flush is requested.
  a_no_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.migrated |->
      out_item_o.flush_first == 2'd0 && out_item_o.flush_second == 2'd0)
    else $error("flush requested without migration");

  // A current fetch remainder is below a nonzero interval.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stale_q && interval_q != '0 && state_q != S_DIV |-> rem_q < interval_q)
    else $error("fetch remainder out of range");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for invalidation_driven_thread_migrator.
// Holds a predictor, a queue-fed driver, a result monitor and an APB register driver.
// Depends on idtm_pkg and the block's top-level module.

module tb;
  import idtm_pkg::*;

  // Mode 3 has no meaning in the block and has no package constant.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned MAX_REPORTS = 10;

  // Clock, reset and everything the testbench drives. All inputs start known.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  idtm_in_t    in_item_i = '0;
  logic        out_stall_i = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;

  logic        in_stall_o;
  logic        out_valid_o;
  idtm_out_t   out_item_o;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state: pair counters indexed writer*4+victim, the thread map,
  // the free-running fetch counter and a shadow of the four registers.
  logic [31:0] pair_cnt [16];
  logic [1:0]  vcore_of [4];
  logic [31:0] fetch_ticks;
  logic        mig_on;
  logic [31:0] check_every;
  logic [8:0]  share_thresh;
  logic [8:0]  keep_frac;

  // Items waiting for the driver, and expected results waiting for the monitor.
  idtm_in_t    pending_items [$];
  idtm_out_t   expected_results [$];
  idtm_out_t   oldest;

  // Bookkeeping. The counters that other processes read at the falling edge
  // are updated with nonblocking assignments at the rising edge.
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  logic        in_fire = 1'b0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        calm;

  invalidation_driven_thread_migrator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // A window of items in which neither side idles at all.
  assign calm = (items_taken >= 1000) && (items_taken < 1250);

  // Counts a failure; only the first few are described on the console.
  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("MISMATCH: %s", msg);
    end
  endtask

  // Works out the result of one item and advances the predictor state.
  // The virtual id is read from the map before any swap that the item causes.
  function automatic idtm_out_t model_access(input idtm_in_t it);
    idtm_out_t   res;
    logic [32:0] bumped;
    logic [63:0] cand [4];
    logic [63:0] total;
    logic [63:0] scaled;
    logic [1:0]  lo;
    logic [1:0]  hi;
    logic [1:0]  held;
    int          w;
    int          v;
    int          k;
    int          best;
    res = '0;
    if (it.mode == MODE_FETCH || it.mode == MODE_LOOKUP) begin
      res.virtual_id = mig_on ? vcore_of[it.hw_thread] : it.hw_thread;
    end
    if (it.mode == MODE_FETCH) begin
      // Every fetch counts, enabled or not. A zero interval means a check only
      // when the 32-bit counter wraps around to zero.
      fetch_ticks = fetch_ticks + 32'd1;
      if (mig_on && ((check_every == 32'd0) ? (fetch_ticks == 32'd0)
                                            : (fetch_ticks % check_every == 32'd0))) begin
        // The total covers all twelve off-diagonal counters, that is the six
        // symmetric pairs; the diagonal is never counted into.
        total = '0;
        for (w = 0; w < 4; w++) begin
          for (v = 0; v < 4; v++) begin
            if (w != v) begin
              total = total + {32'b0, pair_cnt[w * 4 + v]};
            end
          end
        end
        // Cross-L2 candidates in the order 0-2, 0-3, 1-2, 1-3.
        for (k = 0; k < 4; k++) begin
          cand[k] = {32'b0, pair_cnt[(k / 2) * 4 + 2 + (k % 2)]}
                  + {32'b0, pair_cnt[(2 + (k % 2)) * 4 + (k / 2)]};
        end
        // Strictly greater wins, so the earlier candidate keeps a tie.
        best = 0;
        for (k = 1; k < 4; k++) begin
          if (cand[k] > cand[best]) begin
            best = k;
          end
        end
        // No migration on an empty total; a threshold above one never passes
        // unless the total is zero, which is already excluded.
        if (total != 64'd0 && total * share_thresh <= (cand[best] << 8)) begin
          // Pair 0-2 swaps entries 0 and 3, 0-3 swaps 0 and 2, and likewise
          // for core 1: the partner across the L2 boundary is 3 or 2.
          lo = (best < 2) ? 2'd0 : 2'd1;
          hi = (best % 2 == 0) ? 2'd3 : 2'd2;
          held = vcore_of[lo];
          vcore_of[lo] = vcore_of[hi];
          vcore_of[hi] = held;
          res.migrated = 1'b1;
          res.flush_first = lo;
          res.flush_second = hi;
          // Truncating Q1.8 scale; a fraction above one grows the counters up to saturation.
          for (k = 0; k < 16; k++) begin
            scaled = ({32'b0, pair_cnt[k]} * keep_frac) >> 8;
            pair_cnt[k] = (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
          end
        end
      end
    end else if (it.mode == MODE_INVAL && it.writer_core != it.victim_core) begin
      // A report where the writer is also the victim is ignored.
      bumped = {1'b0, pair_cnt[{it.writer_core, it.victim_core}]} + it.invalidated_lines;
      pair_cnt[{it.writer_core, it.victim_core}] = bumped[32] ? 32'hFFFF_FFFF : bumped[31:0];
    end
    return res;
  endfunction

  // Input driver: a new item goes out only when the current one has been taken
  // (or none is on offer), so a stalled item never changes. Whether to idle is
  // decided without looking at the stall.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
        in_item_i <= pending_items.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off that lets the block
  // fill up and push back on its input while the driver keeps offering items.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 500) begin
      out_stall_i <= 1'b1;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 21);
    end
  end

  // Monitor: results are checked before the item taken at the same edge is
  // predicted, since a result can never belong to an item taken in its own cycle.
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result with nothing expected: vid %0d mig %0d flush %0d,%0d",
                                 out_item_o.virtual_id, out_item_o.migrated,
                                 out_item_o.flush_first, out_item_o.flush_second));
        end else begin
          oldest = expected_results.pop_front();
          if (out_item_o.virtual_id !== oldest.virtual_id ||
              out_item_o.migrated !== oldest.migrated ||
              out_item_o.flush_first !== oldest.flush_first ||
              out_item_o.flush_second !== oldest.flush_second) begin
            note_failure($sformatf({"result %0d: expected vid %0d mig %0d flush %0d,%0d, ",
                                    "got vid %0d mig %0d flush %0d,%0d"}, results_seen,
                                   oldest.virtual_id, oldest.migrated,
                                   oldest.flush_first, oldest.flush_second,
                                   out_item_o.virtual_id, out_item_o.migrated,
                                   out_item_o.flush_first, out_item_o.flush_second));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        items_taken <= items_taken + 1;
        expected_results.push_back(model_access(in_item_i));
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Reads one register back over APB and compares it with the shadow copy.
  // Called at a falling edge with the bus idle; returns one falling edge after
  // the bus goes idle again.
  task automatic check_reg(input logic [1:0] idx);
    logic [31:0] want;
    case (idx)
      REG_ENABLE:   want = {31'b0, mig_on};
      REG_INTERVAL: want = check_every;
      REG_THRESH:   want = {23'b0, share_thresh};
      default:      want = {23'b0, keep_frac};
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      note_failure($sformatf("register %0d read back %0h, expected %0h", idx, prdata, want));
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Setup and access cycle of one APB write, then the shadow update and a read.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ENABLE:   mig_on = value[0];
      REG_INTERVAL: check_every = value;
      REG_THRESH:   share_thresh = value[8:0];
      default:      keep_frac = value[8:0];
    endcase
    @(negedge clk_i);
    check_reg(idx);
  endtask

  task automatic queue_item(input logic [1:0] mode, input logic [1:0] tid,
                            input logic [1:0] writer, input logic [1:0] victim,
                            input logic [3:0] lines);
    idtm_in_t it;
    it.mode = mode;
    it.hw_thread = tid;
    it.writer_core = writer;
    it.victim_core = victim;
    it.invalidated_lines = lines;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Random item: mostly invalidation reports and fetches, so that checks come
  // often and find something to act on. Reports lean toward one cross-L2 pair
  // so that its share can reach the threshold.
  function automatic idtm_in_t random_event(input int unsigned hot_pct,
                                            input logic [1:0] hot_k);
    idtm_in_t    it;
    int unsigned roll;
    logic [1:0]  swap;
    it.hw_thread = 2'($urandom_range(3));
    it.writer_core = 2'($urandom_range(3));
    it.victim_core = 2'($urandom_range(3));
    it.invalidated_lines = ($urandom_range(9) == 0) ? 4'hF : 4'($urandom_range(15));
    roll = $urandom_range(99);
    if (roll < 40) begin
      it.mode = MODE_INVAL;
    end else if (roll < 75) begin
      it.mode = MODE_FETCH;
    end else if (roll < 93) begin
      it.mode = MODE_LOOKUP;
    end else begin
      it.mode = MODE_UNUSED;
    end
    if (it.mode == MODE_INVAL && $urandom_range(99) < hot_pct) begin
      it.writer_core = {1'b0, hot_k[1]};
      it.victim_core = {1'b1, hot_k[0]};
      if ($urandom_range(1) == 1) begin
        swap = it.writer_core;
        it.writer_core = it.victim_core;
        it.victim_core = swap;
      end
    end
    return it;
  endfunction

  // Blocks until every item handed to the driver has produced its result.
  task automatic wait_drained;
    while (results_seen < items_queued) @(negedge clk_i);
  endtask

  // One random phase: new register settings while idle, then a burst of items.
  task automatic run_phase(input logic en, input logic [31:0] interval,
                           input logic [8:0] thresh, input logic [8:0] keep,
                           input int unsigned hot_pct, input int unsigned count);
    logic [1:0]  hot_k;
    int unsigned n;
    wait_drained();
    write_reg(REG_ENABLE, {31'b0, en});
    write_reg(REG_INTERVAL, interval);
    write_reg(REG_THRESH, {23'b0, thresh});
    write_reg(REG_KEEP, {23'b0, keep});
    // Items are queued at a rising edge so the driver never races the fill.
    @(posedge clk_i);
    hot_k = 2'd0;
    for (n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        hot_k = 2'($urandom_range(3));
      end
      pending_items.push_back(random_event(hot_pct, hot_k));
    end
    items_queued += count;
  endtask

  initial begin
    int k;
    // Predictor starts in the reset state of the block.
    for (k = 0; k < 16; k++) begin
      pair_cnt[k] = '0;
    end
    for (k = 0; k < 4; k++) begin
      vcore_of[k] = 2'(k);
    end
    fetch_ticks = '0;
    mig_on = 1'b0;
    check_every = INTERVAL_RST;
    share_thresh = THRESH_RST;
    keep_frac = KEEP_RST;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Registers must come out of reset with their documented values.
    check_reg(REG_ENABLE);
    check_reg(REG_INTERVAL);
    check_reg(REG_THRESH);
    check_reg(REG_KEEP);

    // Directed part: a check every second fetch, half the counts kept.
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_INTERVAL, 32'd2);
    write_reg(REG_THRESH, 32'd85);
    write_reg(REG_KEEP, 32'd128);
    @(posedge clk_i);
    // Identity map on every thread id.
    queue_item(MODE_LOOKUP, 2'd0, 2'd0, 2'd0, 4'd0);
    queue_item(MODE_LOOKUP, 2'd1, 2'd3, 2'd3, 4'hF);
    queue_item(MODE_LOOKUP, 2'd2, 2'd0, 2'd0, 4'd0);
    queue_item(MODE_LOOKUP, 2'd3, 2'd3, 2'd3, 4'hF);
    // A check with nothing counted must not migrate.
    queue_item(MODE_FETCH, 2'd0, 2'd0, 2'd0, 4'd0);
    queue_item(MODE_FETCH, 2'd3, 2'd0, 2'd0, 4'd0);
    // The meaningless mode with every bit set, and a self-invalidation.
    queue_item(MODE_UNUSED, 2'd3, 2'd3, 2'd3, 4'hF);
    queue_item(MODE_INVAL, 2'd0, 2'd2, 2'd2, 4'hF);
    // Pairs 1-3 and 0-2 tie; the earlier pair 0-2 must win. Zero lines too.
    queue_item(MODE_INVAL, 2'd0, 2'd1, 2'd3, 4'hF);
    queue_item(MODE_INVAL, 2'd0, 2'd3, 2'd1, 4'd0);
    queue_item(MODE_INVAL, 2'd0, 2'd0, 2'd2, 4'hF);
    queue_item(MODE_INVAL, 2'd0, 2'd2, 2'd0, 4'd0);
    queue_item(MODE_FETCH, 2'd1, 2'd0, 2'd0, 4'd0);
    queue_item(MODE_FETCH, 2'd2, 2'd0, 2'd0, 4'd0);
    // Threads 0 and 3 now sit on swapped cores.
    queue_item(MODE_LOOKUP, 2'd0, 2'd0, 2'd0, 4'd0);
    queue_item(MODE_LOOKUP, 2'd3, 2'd0, 2'd0, 4'd0);
    // A non-cross pair adds to the total only; then 0-3 takes over.
    queue_item(MODE_INVAL, 2'd0, 2'd0, 2'd1, 4'hF);
    queue_item(MODE_INVAL, 2'd0, 2'd3, 2'd0, 4'hF);
    queue_item(MODE_FETCH, 2'd0, 2'd0, 2'd0, 4'd0);
    queue_item(MODE_FETCH, 2'd3, 2'd0, 2'd0, 4'd0);

    // Random phases over a spread of settings, extremes included: disabled,
    // interval one, zero and all ones, threshold zero, one and above one,
    // keep fraction zero, one and above one (counters grow until saturated).
    run_phase(1'b1, 32'd3,          9'd85,  9'd0,   70, 250);
    run_phase(1'b0, 32'd5,          9'd85,  9'd128, 50, 150);
    run_phase(1'b1, 32'd1,          9'd0,   9'd511, 30, 200);
    run_phase(1'b1, 32'hFFFF_FFFF,  9'd256, 9'd256, 50, 100);
    run_phase(1'b1, 32'd0,          9'd128, 9'd64,  50, 100);
    run_phase(1'b1, 32'd2,          9'd256, 9'd0,   95, 200);
    run_phase(1'b1, 32'd4,          9'd511, 9'd200, 80, 150);
    run_phase(1'b1, 32'd7,          9'd170, 9'd256, 60, 300);
    run_phase(1'b1, 32'd1,          9'd100, 9'd0,   40, 280);

    // Let a slow migration finish and catch any stray result.
    wait_drained();
    repeat (300) @(negedge clk_i);
    fail_count += expected_results.size();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
